### sv/abkf_pkg.sv
// Shared types, codes and saturation helpers for the angle/bias Kalman filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package abkf_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_Q_ANGLE = 2'd0;
   localparam logic [1:0] CSR_Q_BIAS  = 2'd1;
   localparam logic [1:0] CSR_R_MEAS  = 2'd2;

   localparam logic [15:0] Q_ANGLE_RESET = 16'd10;
   localparam logic [15:0] Q_BIAS_RESET  = 16'd30;
   localparam logic [19:0] R_MEAS_RESET  = 20'd3000;

   // quotient width handed to the gain divider
   localparam logic [5:0] GAIN_BITS   = 6'd47;

   localparam logic [46:0] GAIN_LIM = 47'h7FFF_FFFF_FFFF;
   localparam logic [60:0] PROD_LIM = 61'h1000_0000_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GO,
      ST_WAIT,
      ST_WB,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      STEP_QA,
      STEP_QB,
      STEP_RM,
      STEP_GM,
      STEP_RATE,
      STEP_P11,
      STEP_T,
      STEP_QBDT,
      STEP_K0,
      STEP_K1,
      STEP_K0Y,
      STEP_K1Y,
      STEP_K1P00,
      STEP_K0P00,
      STEP_K1P01,
      STEP_K0P01
   } step_type;

   typedef struct packed {
      logic     load_in;
      logic     start_div;
      logic     start_cdiv;
      logic     start_mul;
      logic     wb;
      logic     load_out;
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic cdiv_done;
      logic mul_done;
   } status_type;

   function automatic logic is_div_step(input step_type s);
      return (s == STEP_K0) || (s == STEP_K1);
   endfunction

   // divisions by a fixed constant, done by reciprocal multiplication
   function automatic logic is_cdiv_step(input step_type s);
      return (s == STEP_QA) || (s == STEP_QB) || (s == STEP_RM) || (s == STEP_GM);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < 64'shFFFF_FFFF_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      logic signed [47:0] r;
      if (v > 64'sh0000_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
      else if (v < 64'shFFFF_8000_0000_0000) r = 48'sh8000_0000_0000;
      else r = v[47:0];
      return r;
   endfunction

endpackage

### sv/abkf_div.sv
// Restoring divider, one quotient bit per cycle, rounding folded into the dividend.
// Flags overflow when the quotient would not fit the requested bit count.
module abkf_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [80:0] numer,
   input  logic [48:0] denom,
   input  logic [5:0]  nbits,
   output logic        done,
   output logic        ovf,
   output logic [46:0] quot
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        ovf_ff, ovf_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [48:0] rem_ff, rem_in;
   logic [48:0] den_ff, den_in;
   logic [80:0] num_ff, num_in;
   logic [46:0] quot_ff, quot_in;
   logic [80:0] head;
   logic [49:0] trial;
   logic [6:0]  bidx;

   always_comb begin
      head    = numer >> nbits;
      bidx    = 7'(cnt_ff) - 7'd1;
      trial   = {rem_ff, num_ff[bidx]};
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      if (start) begin
         den_in  = denom;
         num_in  = numer;
         cnt_in  = nbits;
         quot_in = '0;
         rem_in  = head[48:0];
         if (head >= 81'(denom)) begin
            // quotient too large: finish at once
            ovf_in  = 1'b1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            ovf_in  = 1'b0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial >= 50'(den_ff)) begin
            rem_in  = 49'(trial - 50'(den_ff));
            quot_in = {quot_ff[45:0], 1'b1};
         end else begin
            rem_in  = trial[48:0];
            quot_in = {quot_ff[45:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign ovf  = ovf_ff;
   assign quot = quot_ff;

endmodule

### sv/abkf_mul.sv
// Magnitude multiplier: 64 x 48 bits as three 64 x 16 partial products, then a
// rounding shift by 24 or 32 and a clamp at 2^60. Uses abkf_pkg.
module abkf_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a_mag,
   input  logic [47:0] b_mag,
   input  logic        sh32,
   output logic        done,
   output logic [60:0] prod_q
);

   logic         busy_ff, busy_in;
   logic         rnd_ff, rnd_in;
   logic         done_ff, done_in;
   logic [1:0]   dig_ff, dig_in;
   logic [63:0]  a_ff, a_in;
   logic [47:0]  b_ff, b_in;
   logic         sh32_ff, sh32_in;
   logic [64:0]  hi_ff, hi_in;
   logic [47:0]  lo_ff, lo_in;
   logic [60:0]  q_ff, q_in;
   logic [79:0]  part;
   logic [80:0]  sum;
   logic [112:0] rounded;
   logic [112:0] shifted;

   always_comb begin
      part    = a_ff * b_ff[15:0];
      sum     = 81'(hi_ff) + 81'(part);
      rounded = {hi_ff, lo_ff} + (sh32_ff ? (113'd1 << 31) : (113'd1 << 23));
      shifted = sh32_ff ? (rounded >> 32) : (rounded >> 24);
      busy_in = busy_ff;
      rnd_in  = 1'b0;
      done_in = 1'b0;
      dig_in  = dig_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      sh32_in = sh32_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      if (start) begin
         a_in    = a_mag;
         b_in    = b_mag;
         sh32_in = sh32;
         hi_in   = '0;
         lo_in   = '0;
         dig_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // accumulate one digit, shift the low 16 bits out
         hi_in  = 65'(sum >> 16);
         lo_in  = {sum[15:0], lo_ff[47:16]};
         b_in   = b_ff >> 16;
         dig_in = dig_ff + 2'd1;
         if (dig_ff == 2'd2) begin
            busy_in = 1'b0;
            rnd_in  = 1'b1;
         end
      end else if (rnd_ff) begin
         q_in    = (shifted > 113'(abkf_pkg::PROD_LIM)) ? abkf_pkg::PROD_LIM : shifted[60:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rnd_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rnd_ff  <= rnd_in;
         done_ff <= done_in;
      end
      dig_ff  <= dig_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      sh32_ff <= sh32_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      q_ff    <= q_in;
   end

   assign done   = done_ff;
   assign prod_q = q_ff;

endmodule

### sv/abkf_ctrl.sv
// Sequencer for the filter update: walks the step list, starting the divider, the
// constant divider or the multiplier for each step and committing its result. Uses abkf_pkg.
module abkf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  abkf_pkg::status_type   status,
   output abkf_pkg::cmd_type      cmd
);

   abkf_pkg::state_type state_ff, state_in;
   abkf_pkg::step_type  step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                div_step;
   logic                cdiv_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abkf_pkg::ST_IDLE;
         step_ff      <= abkf_pkg::STEP_QA;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      div_step     = abkf_pkg::is_div_step(step_ff);
      cdiv_step    = abkf_pkg::is_cdiv_step(step_ff);
      state_in     = state_ff;
      step_in      = step_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.step     = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         abkf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               step_in     = abkf_pkg::STEP_QA;
               state_in    = abkf_pkg::ST_GO;
            end
         end
         abkf_pkg::ST_GO: begin
            cmd.start_div  = div_step;
            cmd.start_cdiv = cdiv_step;
            cmd.start_mul  = !div_step && !cdiv_step;
            state_in       = abkf_pkg::ST_WAIT;
         end
         abkf_pkg::ST_WAIT: begin
            if ((div_step && status.div_done) || (cdiv_step && status.cdiv_done) ||
                (!div_step && !cdiv_step && status.mul_done)) begin
               state_in = abkf_pkg::ST_WB;
            end
         end
         abkf_pkg::ST_WB: begin
            cmd.wb = 1'b1;
            if (step_ff == abkf_pkg::STEP_K0P01) begin
               state_in = abkf_pkg::ST_DONE;
            end else begin
               step_in  = abkf_pkg::step_type'(step_ff + 4'd1);
               state_in = abkf_pkg::ST_GO;
            end
         end
         abkf_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = abkf_pkg::ST_IDLE;
            end
         end
         default: state_in = abkf_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/abkf_dpath.sv
// Filter datapath: configuration, filter state, operand selection and write-back,
// with the shared divider, multiplier and constant divider. Uses abkf_pkg, abkf_div, abkf_mul.
module abkf_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [19:0]          csr_wdata,
   input  logic signed [15:0]   req_gyro_rate_raw,
   input  logic signed [24:0]   req_measured_angle,
   input  logic [23:0]          req_time_step,
   input  abkf_pkg::cmd_type    cmd,
   output abkf_pkg::status_type status,
   output logic signed [31:0]   rsp_filtered_angle,
   output logic signed [31:0]   rsp_gyro_bias
);

   // x*2^s/d split as x*whole + (x*part + half)/d', the last by reciprocal and shift
   localparam logic [18:0] QN_WHOLE = 19'd429496;
   localparam logic [11:0] QN_PART  = 12'd456;
   localparam logic [10:0] QN_HALF  = 11'd312;
   localparam logic [32:0] QN_RECIP = 33'd54975582;
   localparam logic [5:0]  QN_SHIFT = 6'd35;
   localparam logic [18:0] RN_WHOLE = 19'd42949;
   localparam logic [11:0] RN_PART  = 12'd2103;
   localparam logic [10:0] RN_HALF  = 11'd1562;
   localparam logic [32:0] RN_RECIP = 33'd5629499535;
   localparam logic [5:0]  RN_SHIFT = 6'd44;
   localparam logic [18:0] GM_WHOLE = 19'd500;
   localparam logic [11:0] GM_PART  = 12'd36;
   localparam logic [10:0] GM_HALF  = 11'd65;
   localparam logic [32:0] GM_RECIP = 33'd4098252;
   localparam logic [5:0]  GM_SHIFT = 6'd29;

   logic [15:0]        q_angle_ff, q_bias_ff;
   logic [19:0]        r_meas_ff;
   logic signed [15:0] gyro_ff;
   logic signed [24:0] meas_ff;
   logic [23:0]        dt_ff;
   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [47:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic [34:0]        qa_ff, qa_in, qb_ff, qb_in;
   logic [35:0]        rm_ff, rm_in;
   logic signed [33:0] rate_ff, rate_in, y_ff, y_in;
   logic signed [63:0] t_ff, t_in;
   logic signed [49:0] s_ff, s_in;
   logic signed [47:0] k0_ff, k0_in, k1_ff, k1_in;
   logic signed [31:0] out_angle_ff, out_bias_ff;

   logic [80:0]        div_num;
   logic [48:0]        div_den;
   logic [5:0]         div_k;
   logic               div_done, div_ovf;
   logic [46:0]        div_quot;
   logic signed [63:0] mul_a;
   logic signed [47:0] mul_b;
   logic               mul_sh32, mul_done;
   logic [63:0]        a_mag;
   logic [47:0]        b_mag;
   logic [60:0]        mul_q;
   logic               mul_neg;
   logic signed [63:0] prod_s;
   logic [16:0]        gyro_mag;
   logic [47:0]        p00_mag, p10_mag;
   logic [49:0]        s_mag;
   logic               s_zero;
   logic signed [33:0] gm_s;
   logic [46:0]        k_mag;
   logic signed [47:0] k_pos;
   logic signed [47:0] k0_val, k1_val;

   logic [19:0]        cd_x;
   logic [18:0]        cd_whole;
   logic [11:0]        cd_part;
   logic [10:0]        cd_half;
   logic [32:0]        cd_recip, cd_recip_ff;
   logic [5:0]         cd_shift, cd_shift_ff;
   logic [35:0]        cd_hi_ff;
   logic [31:0]        cd_lo_ff;
   logic [64:0]        cd_prod_ff;
   logic [35:0]        cd_quot_ff;
   logic               cd_v1_ff, cd_v2_ff, cd_done_ff;

   assign gyro_mag = gyro_ff[15] ? 17'(-17'(gyro_ff)) : 17'(gyro_ff);
   assign p00_mag  = p00_ff[47] ? 48'(-p00_ff) : 48'(p00_ff);
   assign p10_mag  = p10_ff[47] ? 48'(-p10_ff) : 48'(p10_ff);
   assign s_mag    = s_ff[49] ? 50'(-s_ff) : 50'(s_ff);
   assign s_zero   = (s_ff == '0);

   // operand selection for the current step
   always_comb begin
      div_num  = '0;
      div_den  = '0;
      div_k    = '0;
      mul_a    = '0;
      mul_b    = '0;
      mul_sh32 = 1'b0;
      cd_x     = '0;
      cd_whole = '0;
      cd_part  = '0;
      cd_half  = '0;
      cd_recip = '0;
      cd_shift = '0;
      unique case (cmd.step)
         abkf_pkg::STEP_QA: begin
            cd_x     = {4'd0, q_angle_ff};
            cd_whole = QN_WHOLE;
            cd_part  = QN_PART;
            cd_half  = QN_HALF;
            cd_recip = QN_RECIP;
            cd_shift = QN_SHIFT;
         end
         abkf_pkg::STEP_QB: begin
            cd_x     = {4'd0, q_bias_ff};
            cd_whole = QN_WHOLE;
            cd_part  = QN_PART;
            cd_half  = QN_HALF;
            cd_recip = QN_RECIP;
            cd_shift = QN_SHIFT;
         end
         abkf_pkg::STEP_RM: begin
            cd_x     = r_meas_ff;
            cd_whole = RN_WHOLE;
            cd_part  = RN_PART;
            cd_half  = RN_HALF;
            cd_recip = RN_RECIP;
            cd_shift = RN_SHIFT;
         end
         abkf_pkg::STEP_GM: begin
            cd_x     = {3'd0, gyro_mag};
            cd_whole = GM_WHOLE;
            cd_part  = GM_PART;
            cd_half  = GM_HALF;
            cd_recip = GM_RECIP;
            cd_shift = GM_SHIFT;
         end
         abkf_pkg::STEP_RATE: begin
            mul_a = 64'(rate_ff);
            mul_b = $signed({24'd0, dt_ff});
         end
         abkf_pkg::STEP_P11: begin
            mul_a = 64'(p11_ff);
            mul_b = $signed({24'd0, dt_ff});
         end
         abkf_pkg::STEP_T: begin
            mul_a = t_ff;
            mul_b = $signed({24'd0, dt_ff});
         end
         abkf_pkg::STEP_QBDT: begin
            mul_a = $signed({29'd0, qb_ff});
            mul_b = $signed({24'd0, dt_ff});
         end
         abkf_pkg::STEP_K0: begin
            div_num = 81'({p00_mag, 32'd0}) + 81'(s_mag >> 1);
            div_den = s_mag[48:0];
            div_k   = abkf_pkg::GAIN_BITS;
         end
         abkf_pkg::STEP_K1: begin
            div_num = 81'({p10_mag, 32'd0}) + 81'(s_mag >> 1);
            div_den = s_mag[48:0];
            div_k   = abkf_pkg::GAIN_BITS;
         end
         abkf_pkg::STEP_K0Y: begin
            mul_a    = 64'(k0_ff);
            mul_b    = 48'(y_ff);
            mul_sh32 = 1'b1;
         end
         abkf_pkg::STEP_K1Y: begin
            mul_a    = 64'(k1_ff);
            mul_b    = 48'(y_ff);
            mul_sh32 = 1'b1;
         end
         abkf_pkg::STEP_K1P00: begin
            mul_a    = 64'(k1_ff);
            mul_b    = p00_ff;
            mul_sh32 = 1'b1;
         end
         abkf_pkg::STEP_K0P00: begin
            mul_a    = 64'(k0_ff);
            mul_b    = p00_ff;
            mul_sh32 = 1'b1;
         end
         abkf_pkg::STEP_K1P01: begin
            mul_a    = 64'(k1_ff);
            mul_b    = p01_ff;
            mul_sh32 = 1'b1;
         end
         abkf_pkg::STEP_K0P01: begin
            mul_a    = 64'(k0_ff);
            mul_b    = p01_ff;
            mul_sh32 = 1'b1;
         end
         default: ;
      endcase
   end

   // constant divider: whole part and remainder term, reciprocal product, then sum
   always_ff @(posedge clock) begin
      if (reset) begin
         cd_v1_ff   <= 1'b0;
         cd_v2_ff   <= 1'b0;
         cd_done_ff <= 1'b0;
      end else begin
         cd_v1_ff   <= cmd.start_cdiv;
         cd_v2_ff   <= cd_v1_ff;
         cd_done_ff <= cd_v2_ff;
      end
      if (cmd.start_cdiv) begin
         cd_hi_ff    <= 36'(cd_x) * 36'(cd_whole);
         cd_lo_ff    <= 32'(cd_x) * 32'(cd_part) + 32'(cd_half);
         cd_recip_ff <= cd_recip;
         cd_shift_ff <= cd_shift;
      end
      cd_prod_ff <= 65'(cd_lo_ff) * 65'(cd_recip_ff);
      cd_quot_ff <= cd_hi_ff + 36'(cd_prod_ff >> cd_shift_ff);
   end

   assign a_mag   = mul_a[63] ? 64'(-mul_a) : 64'(mul_a);
   assign b_mag   = mul_b[47] ? 48'(-mul_b) : 48'(mul_b);
   assign mul_neg = mul_a[63] ^ mul_b[47];
   assign prod_s  = mul_neg ? -$signed({3'd0, mul_q}) : $signed({3'd0, mul_q});

   assign gm_s  = $signed({10'd0, cd_quot_ff[23:0]});
   assign k_mag = div_ovf ? abkf_pkg::GAIN_LIM : div_quot;
   assign k_pos = $signed({1'b0, k_mag});
   assign k0_val = s_zero ? 48'sd0 : ((p00_ff[47] ^ s_ff[49]) ? -k_pos : k_pos);
   assign k1_val = s_zero ? 48'sd0 : ((p10_ff[47] ^ s_ff[49]) ? -k_pos : k_pos);

   // write-back of the finished step
   always_comb begin
      angle_in = angle_ff;
      bias_in  = bias_ff;
      p00_in   = p00_ff;
      p01_in   = p01_ff;
      p10_in   = p10_ff;
      p11_in   = p11_ff;
      qa_in    = qa_ff;
      qb_in    = qb_ff;
      rm_in    = rm_ff;
      rate_in  = rate_ff;
      y_in     = y_ff;
      t_in     = t_ff;
      s_in     = s_ff;
      k0_in    = k0_ff;
      k1_in    = k1_ff;
      if (cmd.wb) begin
         unique case (cmd.step)
            abkf_pkg::STEP_QA: qa_in = cd_quot_ff[34:0];
            abkf_pkg::STEP_QB: qb_in = cd_quot_ff[34:0];
            abkf_pkg::STEP_RM: rm_in = cd_quot_ff;
            abkf_pkg::STEP_GM: rate_in = (gyro_ff[15] ? -gm_s : gm_s) - 34'(bias_ff);
            abkf_pkg::STEP_RATE: angle_in = abkf_pkg::sat32(64'(angle_ff) + prod_s);
            abkf_pkg::STEP_P11: begin
               // t takes the off-diagonal terms before they move
               t_in   = prod_s - 64'(p01_ff) - 64'(p10_ff) + $signed({29'd0, qa_ff});
               p01_in = abkf_pkg::sat48(64'(p01_ff) - prod_s);
               p10_in = abkf_pkg::sat48(64'(p10_ff) - prod_s);
            end
            abkf_pkg::STEP_T: p00_in = abkf_pkg::sat48(64'(p00_ff) + prod_s);
            abkf_pkg::STEP_QBDT: begin
               p11_in = abkf_pkg::sat48(64'(p11_ff) + prod_s);
               s_in   = 50'(p00_ff) + $signed({14'd0, rm_ff});
               y_in   = 34'(meas_ff) - 34'(angle_ff);
            end
            abkf_pkg::STEP_K0: k0_in = k0_val;
            abkf_pkg::STEP_K1: k1_in = k1_val;
            abkf_pkg::STEP_K0Y: angle_in = abkf_pkg::sat32(64'(angle_ff) + prod_s);
            abkf_pkg::STEP_K1Y: bias_in = abkf_pkg::sat32(64'(bias_ff) + prod_s);
            abkf_pkg::STEP_K1P00: p10_in = abkf_pkg::sat48(64'(p10_ff) - prod_s);
            abkf_pkg::STEP_K0P00: p00_in = abkf_pkg::sat48(64'(p00_ff) - prod_s);
            abkf_pkg::STEP_K1P01: p11_in = abkf_pkg::sat48(64'(p11_ff) - prod_s);
            abkf_pkg::STEP_K0P01: p01_in = abkf_pkg::sat48(64'(p01_ff) - prod_s);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_angle_ff <= abkf_pkg::Q_ANGLE_RESET;
         q_bias_ff  <= abkf_pkg::Q_BIAS_RESET;
         r_meas_ff  <= abkf_pkg::R_MEAS_RESET;
         angle_ff   <= '0;
         bias_ff    <= '0;
         p00_ff     <= '0;
         p01_ff     <= '0;
         p10_ff     <= '0;
         p11_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               abkf_pkg::CSR_Q_ANGLE: q_angle_ff <= csr_wdata[15:0];
               abkf_pkg::CSR_Q_BIAS:  q_bias_ff  <= csr_wdata[15:0];
               abkf_pkg::CSR_R_MEAS:  r_meas_ff  <= csr_wdata;
               default: ;
            endcase
         end
         angle_ff <= angle_in;
         bias_ff  <= bias_in;
         p00_ff   <= p00_in;
         p01_ff   <= p01_in;
         p10_ff   <= p10_in;
         p11_ff   <= p11_in;
      end
      qa_ff   <= qa_in;
      qb_ff   <= qb_in;
      rm_ff   <= rm_in;
      rate_ff <= rate_in;
      y_ff    <= y_in;
      t_ff    <= t_in;
      s_ff    <= s_in;
      k0_ff   <= k0_in;
      k1_ff   <= k1_in;
      if (cmd.load_in) begin
         gyro_ff <= req_gyro_rate_raw;
         meas_ff <= req_measured_angle;
         dt_ff   <= req_time_step;
      end
      if (cmd.load_out) begin
         out_angle_ff <= angle_ff;
         out_bias_ff  <= bias_ff;
      end
   end

   abkf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start_div),
      .numer (div_num),
      .denom (div_den),
      .nbits (div_k),
      .done  (div_done),
      .ovf   (div_ovf),
      .quot  (div_quot)
   );

   abkf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start_mul),
      .a_mag  (a_mag),
      .b_mag  (b_mag),
      .sh32   (mul_sh32),
      .done   (mul_done),
      .prod_q (mul_q)
   );

   assign status.div_done    = div_done;
   assign status.cdiv_done   = cd_done_ff;
   assign status.mul_done    = mul_done;
   assign rsp_filtered_angle = out_angle_ff;
   assign rsp_gyro_bias      = out_bias_ff;

endmodule

### sv/angle_bias_kalman_filter.sv
// Angle/bias Kalman filter top level: one item at a time; each update runs four constant
// divisions by reciprocal, ten products and two gain divisions at one bit a cycle, a
// gain division ending at once when its gain saturates. A finished result waits in the
// output register while the next item is taken, and a stalled receiver holds the
// following result back.
// Synchronous active-high reset clears the filter state and sets noise to 10, 30, 3000.
module angle_bias_kalman_filter (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [19:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_gyro_rate_raw,
   input  logic signed [24:0]  req_measured_angle,
   input  logic [23:0]         req_time_step,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_filtered_angle,
   output logic signed [31:0]  rsp_gyro_bias
);

   abkf_pkg::cmd_type    cmd;
   abkf_pkg::status_type status;

   abkf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   abkf_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_gyro_rate_raw  (req_gyro_rate_raw),
      .req_measured_angle (req_measured_angle),
      .req_time_step      (req_time_step),
      .cmd                (cmd),
      .status             (status),
      .rsp_filtered_angle (rsp_filtered_angle),
      .rsp_gyro_bias      (rsp_gyro_bias)
   );

endmodule

### sv/abkf_checker.sv
// Port-level checks for the angle/bias Kalman filter, bound to the top level.
// Sees the handshake and result ports only.
module abkf_port_checks (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic signed [31:0]  rsp_filtered_angle,
   input logic signed [31:0]  rsp_gyro_bias
);

   // no result may be pending straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one item in flight: an accepted beat drops ready
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held after accepting a beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_filtered_angle) && $stable(rsp_gyro_bias)))
      else $error("result changed while stalled");

endmodule

bind angle_bias_kalman_filter abkf_port_checks u_abkf_port_checks (.*);

### tb/sv/abkf_checker.sv
// Scoreboard for the angle/bias Kalman filter: watches the request, response and
// register ports, predicts each result in fixed point and compares it.
// Depends on abkf_pkg for the register index codes and reset values.
module abkf_checker
   import abkf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [19:0]        csr_wdata,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_gyro_rate_raw,
   input  logic signed [24:0] req_measured_angle,
   input  logic [23:0]        req_time_step,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_filtered_angle,
   input  logic signed [31:0] rsp_gyro_bias,
   output int                 errors,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] bias;
   } estimate_t;

   localparam logic [63:0] GAIN_MAX = 64'h7FFF_FFFF_FFFF;
   localparam logic [63:0] PROD_MAX = 64'h1000_0000_0000_0000;
   localparam longint COV_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint COV_LO = -COV_HI - 1;
   localparam longint EST_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam longint EST_LO = -EST_HI - 1;

   logic [15:0] q_angle_cfg, q_bias_cfg;
   logic [19:0] r_meas_cfg;
   longint angle_est, bias_est, p00, p01, p10, p11;
   estimate_t estimates_due[$];

   assign pending = estimates_due.size();

   function automatic logic [63:0] magnitude(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // round(a*b / 2^sh) to nearest, ties away from zero, clipped to +-lim
   function automatic longint mul_round(input longint a, input longint b, input int sh,
                                        input logic [63:0] lim);
      logic [127:0] p;
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      if (p > {64'd0, lim}) p = {64'd0, lim};
      return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   // round(num*2^32 / den), den nonzero, clipped to +-lim
   function automatic longint div_round(input longint num, input longint den,
                                        input logic [63:0] lim);
      logic [127:0] x;
      logic [127:0] d;
      d = {64'd0, magnitude(den)};
      x = (({64'd0, magnitude(num)}) << 32) + (d >> 1);
      x = x / d;
      if (x > {64'd0, lim}) x = {64'd0, lim};
      return ((num < 0) != (den < 0)) ? -longint'(x[63:0]) : longint'(x[63:0]);
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic kalman_update(input logic signed [15:0] gyro,
                                input logic signed [24:0] meas_in, input logic [23:0] dt_in);
      longint dt, meas, qa, qb, rm, gm, rate, dp11, t, s, k0, k1, y, a00, a01;
      dt = longint'(dt_in);
      meas = longint'(meas_in);
      qa = longint'(((64'(q_angle_cfg) << 32) + 64'd5000) / 64'd10000);
      qb = longint'(((64'(q_bias_cfg) << 32) + 64'd5000) / 64'd10000);
      rm = longint'(((64'(r_meas_cfg) << 32) + 64'd50000) / 64'd100000);
      gm = longint'(((magnitude(longint'(gyro)) << 16) + 64'd65) / 64'd131);
      rate = (gyro < 0 ? -gm : gm) - bias_est;
      k0 = 0;
      k1 = 0;
      // predict
      angle_est = clip(angle_est + mul_round(rate, dt, 24, PROD_MAX), EST_LO, EST_HI);
      dp11 = mul_round(p11, dt, 24, PROD_MAX);
      t = dp11 - p01 - p10 + qa;
      p00 = clip(p00 + mul_round(t, dt, 24, PROD_MAX), COV_LO, COV_HI);
      p01 = clip(p01 - dp11, COV_LO, COV_HI);
      p10 = clip(p10 - dp11, COV_LO, COV_HI);
      p11 = clip(p11 + mul_round(qb, dt, 24, PROD_MAX), COV_LO, COV_HI);
      // correct; a zero innovation variance leaves both gains at zero
      s = p00 + rm;
      if (s != 0) begin
         k0 = div_round(p00, s, GAIN_MAX);
         k1 = div_round(p10, s, GAIN_MAX);
      end
      y = meas - angle_est;
      angle_est = clip(angle_est + mul_round(k0, y, 32, PROD_MAX), EST_LO, EST_HI);
      bias_est = clip(bias_est + mul_round(k1, y, 32, PROD_MAX), EST_LO, EST_HI);
      a00 = p00;
      a01 = p01;
      p00 = clip(p00 - mul_round(k0, a00, 32, PROD_MAX), COV_LO, COV_HI);
      p01 = clip(p01 - mul_round(k0, a01, 32, PROD_MAX), COV_LO, COV_HI);
      p10 = clip(p10 - mul_round(k1, a00, 32, PROD_MAX), COV_LO, COV_HI);
      p11 = clip(p11 - mul_round(k1, a01, 32, PROD_MAX), COV_LO, COV_HI);
      estimates_due.push_back({angle_est[31:0], bias_est[31:0]});
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      estimate_t want;
      if (reset) begin
         q_angle_cfg = Q_ANGLE_RESET;
         q_bias_cfg = Q_BIAS_RESET;
         r_meas_cfg = R_MEAS_RESET;
         angle_est = 0; bias_est = 0;
         p00 = 0; p01 = 0; p10 = 0; p11 = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_Q_ANGLE: q_angle_cfg = csr_wdata[15:0];
               CSR_Q_BIAS:  q_bias_cfg = csr_wdata[15:0];
               CSR_R_MEAS:  r_meas_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (estimates_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat angle=%0d bias=%0d", $realtime,
                        rsp_filtered_angle, rsp_gyro_bias);
            end else begin
               want = estimates_due.pop_front();
               if (rsp_filtered_angle !== want.angle) begin
                  errors++;
                  $display("%0t: filtered_angle expected %0d got %0d", $realtime,
                           want.angle, rsp_filtered_angle);
               end
               if (rsp_gyro_bias !== want.bias) begin
                  errors++;
                  $display("%0t: gyro_bias expected %0d got %0d", $realtime,
                           want.bias, rsp_gyro_bias);
               end
            end
         end
         if (req_valid && req_ready)
            kalman_update(req_gyro_rate_raw, req_measured_angle, req_time_step);
      end
   end

endmodule

### tb/sv/tb_angle_bias_kalman_filter.sv
// Top of the angle/bias Kalman filter testbench: clock, reset, register writes,
// request and response traffic, and the verdict. Depends on abkf_pkg and abkf_checker.
module tb_angle_bias_kalman_filter;
   import abkf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 6000000;
   localparam int RANDOM_ITEMS = 300;

   logic clock, reset;
   logic csr_write_en;
   logic [1:0] csr_index;
   logic [19:0] csr_wdata;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [15:0] req_gyro_rate_raw;
   logic signed [24:0] req_measured_angle;
   logic [23:0] req_time_step;
   logic signed [31:0] rsp_filtered_angle, rsp_gyro_bias;
   int errors, pending;
   int cycles = 0, accepted = 0, returned = 0;
   bit hold_off_now = 0, rx_eager = 0;

   angle_bias_kalman_filter dut (.*);
   abkf_checker scoreboard (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (!reset && req_valid && req_ready) accepted++;
      if (!reset && rsp_valid && rsp_ready) returned++;
      if (cycles > CYCLE_LIMIT) begin
         $display("angle_bias_kalman_filter test failed");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off so the block backs up
   initial begin
      int stall;
      bit held;
      stall = 0;
      held = 0;
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (hold_off_now && !held) begin
            held = 1;
            stall = 3000;
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 0;
         end else if (rx_eager || $urandom_range(0, 99) < 75) begin
            rsp_ready <= 1;
         end else begin
            stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 400)
                                                 : $urandom_range(1, 4);
            rsp_ready <= 0;
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_beat(input logic [15:0] gyro, input logic [24:0] meas,
                            input logic [23:0] dt, input bit gapless);
      int gap;
      gap = 0;
      if (!gapless) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap = 0;
            6, 7, 8: gap = $urandom_range(1, 3);
            default: gap = $urandom_range(10, 60);
         endcase
      end
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_gyro_rate_raw <= gyro;
      req_measured_angle <= meas;
      req_time_step <= dt;
      req_valid <= 1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (returned != accepted) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_regs(input logic [15:0] qa, input logic [15:0] qb,
                             input logic [19:0] rm);
      // upper bits of the 16-bit registers carry junk that must be dropped
      csr_write_en <= 1; csr_index <= CSR_Q_ANGLE;
      csr_wdata <= {4'($urandom), qa};
      @(negedge clock);
      csr_index <= CSR_Q_BIAS; csr_wdata <= {4'($urandom), qb};
      @(negedge clock);
      csr_index <= CSR_R_MEAS; csr_wdata <= rm;
      @(negedge clock);
      csr_index <= 2'd3; csr_wdata <= 20'($urandom);
      @(negedge clock);
      csr_write_en <= 0;
      @(negedge clock);
   endtask

   task automatic random_beats(input int n);
      bit gapless;
      logic [15:0] g;
      logic [24:0] m;
      logic [23:0] dt;
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0) begin
            gapless = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 4) != 0) begin
            g = 16'($urandom_range(0, 8000) - 4000);
            m = 25'($urandom_range(0, 23592960) - 11796480);
            dt = 24'($urandom_range(0, 262144));
         end else begin
            g = 16'($urandom);
            m = 25'($urandom);
            dt = 24'($urandom);
         end
         if (accepted == 150) hold_off_now = 1;
         send_beat(g, m, dt, gapless);
      end
   endtask

   initial begin
      logic [15:0] dir_gyro[12] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0083,
                                    16'hFF7D, 16'h7FFF, 16'h8000, 16'h1234, 16'h0001,
                                    16'h8000, 16'h7FFF};
      logic [24:0] dir_meas[12] = '{25'd11796480, -25'sd11796480, 25'd0, 25'h0FF_FFFF,
                                    25'h100_0000, 25'd65536, 25'h1FF_FFFF, 25'd0,
                                    25'd11796480, -25'sd1, 25'h0FF_FFFF, 25'h100_0000};
      logic [23:0] dir_dt[12] = '{24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 24'd1, 24'd16777,
                                  24'h80_0000, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0,
                                  24'h00_4000, 24'hFF_FFFF, 24'hFF_FFFF};
      reset = 1;
      csr_write_en = 0; csr_index = '0; csr_wdata = '0;
      req_valid = 0; req_gyro_rate_raw = '0; req_measured_angle = '0; req_time_step = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // extremes of every field under the reset noise settings
      foreach (dir_gyro[i]) send_beat(dir_gyro[i], dir_meas[i], dir_dt[i], 0);
      drain();

      // no measurement noise and no elapsed time: the angle variance collapses to zero,
      // then the innovation variance is zero and the gains must be zero
      write_regs(16'd10, 16'd30, 20'd0);
      for (int i = 0; i < 4; i++) send_beat(16'($urandom), 25'($urandom), 24'd0, 0);
      drain();

      random_beats(RANDOM_ITEMS);
      drain();
      write_regs(16'hFFFF, 16'hFFFF, 20'd1000000);
      random_beats(RANDOM_ITEMS);
      drain();
      write_regs(16'd0, 16'd0, 20'd1);
      random_beats(RANDOM_ITEMS);
      drain();
      write_regs(16'hFFFF, 16'd0, 20'hFFFFF);
      random_beats(RANDOM_ITEMS);
      drain();
      write_regs(16'($urandom), 16'($urandom), 20'($urandom_range(0, 1000000)));
      random_beats(RANDOM_ITEMS);
      drain();
      repeat (400) @(negedge clock);

      if (errors == 0 && pending == 0)
         $display("angle_bias_kalman_filter test passed");
      else
         $display("angle_bias_kalman_filter test failed");
      $finish;
   end

endmodule

### angle_bias_kalman_filter.f
sv/abkf_pkg.sv
sv/abkf_div.sv
sv/abkf_mul.sv
sv/abkf_ctrl.sv
sv/abkf_dpath.sv
sv/angle_bias_kalman_filter.sv
sv/abkf_checker.sv
tb/sv/abkf_checker.sv
tb/sv/tb_angle_bias_kalman_filter.sv
